>>> src/sbf_pkg.sv
// Shared types and constants for the store buffer with forwarding.
// No dependencies.
package sbf_pkg;
    localparam int BUFFER_DEPTH = 16;
    localparam int ADDRESS_BITS = 48;
    localparam int PTR_BITS = $clog2(BUFFER_DEPTH);
    localparam int OCC_BITS = $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_STORE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RK_LOAD  = 2'd0,
        RK_STORE = 2'd1,
        RK_FLUSH = 2'd2,
        RK_WRITE = 2'd3
    } kind_t;

    // one word handed from the front to the back
    typedef struct packed {
        kind_t       kind;
        logic [63:0] load_data;
        logic [OCC_BITS-1:0] drains;
    } cmd_t;

    function automatic logic [63:0] bytes_mask(input logic [1:0] code);
        logic [63:0] m;
        unique case (code)
            2'd0: m = 64'h0000_0000_0000_00ff;
            2'd1: m = 64'h0000_0000_0000_ffff;
            2'd2: m = 64'h0000_0000_ffff_ffff;
            default: m = '1;
        endcase
        return m;
    endfunction
endpackage

>>> src/sbf_front.sv
// Front part: accepts words, appends stores, forms load data byte by byte.
// Depends on sbf_pkg; shares the entry store with sbf_back through ports.
module sbf_front import sbf_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid,
    output logic                    ready,
    input  logic [1:0]              operation,
    input  logic [ADDRESS_BITS-1:0] address,
    input  logic [1:0]              size_code,
    input  logic [63:0]             store_data,
    input  logic [63:0]             memory_data,
    input  logic [4:0]              drain_count,
    input  logic [OCC_BITS-1:0]     occupancy,
    input  logic [PTR_BITS-1:0]     head,
    input  logic                    drain_busy,
    input  logic [ADDRESS_BITS-1:0] rd_address,
    input  logic [63:0]             rd_data,
    input  logic [1:0]              rd_size,
    output logic [PTR_BITS-1:0]     rd_index,
    output logic                    push,
    output logic [ADDRESS_BITS-1:0] push_address,
    output logic [63:0]             push_data,
    output logic [1:0]              push_size,
    output logic                    cmd_valid,
    output cmd_t                    cmd,
    input  logic                    cmd_ready
);
    typedef enum logic [1:0] { F_IDLE, F_SCAN, F_SEND } fstate_t;

    fstate_t                 state_reg;
    logic [OCC_BITS-1:0]     k_reg;
    logic [PTR_BITS-1:0]     idx_reg;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [1:0]              size_reg;
    logic [63:0]             val_reg;
    cmd_t                    cmd_reg;
    logic [63:0]             merged;
    logic [OCC_BITS-1:0]     drains;

    // hold off until the back has finished the previous drain
    assign ready     = (state_reg == F_IDLE) && !drain_busy;
    assign rd_index  = idx_reg;
    assign cmd_valid = (state_reg == F_SEND);
    assign cmd       = cmd_reg;

    assign push         = valid && ready && operation == OP_STORE;
    assign push_address = address;
    assign push_data    = store_data & bytes_mask(size_code);
    assign push_size    = size_code;

    // merge one pending entry into the load bytes, oldest to youngest
    always_comb
    begin
        logic [ADDRESS_BITS-1:0] off;
        merged = val_reg;
        for (int i = 0; i < 8; i++) begin
            off = addr_reg + ADDRESS_BITS'(i) - rd_address;
            if (off < (ADDRESS_BITS'(1) << rd_size))
                merged[8*i +: 8] = rd_data[{off[2:0], 3'b000} +: 8];
        end
        merged = merged & bytes_mask(size_reg);
    end

    always_comb
    begin
        if (occupancy >= OCC_BITS'(BUFFER_DEPTH) - OCC_BITS'(operation == OP_STORE)
            || 6'(drain_count) >= 6'(occupancy) + 6'(operation == OP_STORE))
            drains = occupancy + OCC_BITS'(operation == OP_STORE);
        else
            drains = OCC_BITS'(drain_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= F_IDLE;
        end else begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (valid && ready && operation != OP_NONE) begin
                        addr_reg    <= address;
                        size_reg    <= size_code;
                        val_reg     <= memory_data;
                        idx_reg     <= head;
                        k_reg       <= '0;
                        cmd_reg.kind      <= kind_t'(operation);
                        cmd_reg.load_data <= '0;
                        if (operation == OP_FLUSH)
                            cmd_reg.drains <= occupancy;
                        else
                            cmd_reg.drains <= drains;
                        state_reg <= (operation == OP_LOAD) ? F_SCAN : F_SEND;
                    end
                end
                F_SCAN:
                begin
                    if (k_reg == occupancy) begin
                        cmd_reg.load_data <= val_reg & bytes_mask(size_reg);
                        state_reg <= F_SEND;
                    end else begin
                        val_reg <= merged;
                        idx_reg <= (idx_reg == PTR_BITS'(BUFFER_DEPTH - 1)) ? '0
                                   : idx_reg + 1'b1;
                        k_reg   <= k_reg + 1'b1;
                    end
                end
                F_SEND:
                begin
                    if (cmd_ready)
                        state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

>>> src/sbf_back.sv
// Back part: holds the entry store and queue pointers, emits results and drains.
// Depends on sbf_pkg.
module sbf_back import sbf_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [ADDRESS_BITS-1:0] push_address,
    input  logic [63:0]             push_data,
    input  logic [1:0]              push_size,
    input  logic [PTR_BITS-1:0]     rd_index,
    output logic [ADDRESS_BITS-1:0] rd_address,
    output logic [63:0]             rd_data,
    output logic [1:0]              rd_size,
    output logic [OCC_BITS-1:0]     occupancy,
    output logic [PTR_BITS-1:0]     head,
    output logic                    drain_busy,
    input  logic                    cmd_valid,
    input  cmd_t                    cmd,
    output logic                    cmd_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              result_kind,
    output logic [63:0]             load_data,
    output logic [ADDRESS_BITS-1:0] write_address,
    output logic [63:0]             write_data,
    output logic [1:0]              write_size_code,
    output logic                    last
);
    logic [ADDRESS_BITS-1:0] mem_addr [BUFFER_DEPTH];
    logic [63:0]             mem_data [BUFFER_DEPTH];
    logic [1:0]              mem_size [BUFFER_DEPTH];

    logic [PTR_BITS-1:0] head_reg, tail_reg;
    logic [OCC_BITS-1:0] occ_reg, left_reg;
    logic                busy_reg, out_valid_reg;
    logic                take, pop, slot_free;

    assign head       = head_reg;
    assign occupancy  = occ_reg;
    assign drain_busy = busy_reg;
    assign rd_address = mem_addr[rd_index];
    assign rd_data    = mem_data[rd_index];
    assign rd_size    = mem_size[rd_index];
    assign out_valid  = out_valid_reg;

    assign slot_free = !out_valid_reg || out_ready;
    assign cmd_ready = !busy_reg && slot_free;
    assign take      = cmd_valid && cmd_ready;
    assign pop       = busy_reg && slot_free;

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_addr[tail_reg] <= push_address;
            mem_data[tail_reg] <= push_data;
            mem_size[tail_reg] <= push_size;
        end
        if (take) begin
            result_kind     <= cmd.kind;
            load_data       <= cmd.load_data;
            write_address   <= '0;
            write_data      <= '0;
            write_size_code <= '0;
            last            <= (cmd.drains == '0);
        end else if (pop) begin
            result_kind     <= RK_WRITE;
            load_data       <= '0;
            write_address   <= mem_addr[head_reg];
            write_data      <= mem_data[head_reg];
            write_size_code <= mem_size[head_reg];
            last            <= (left_reg == OCC_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            left_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (push)
                tail_reg <= (tail_reg == PTR_BITS'(BUFFER_DEPTH - 1)) ? '0
                            : tail_reg + 1'b1;
            occ_reg <= occ_reg + OCC_BITS'(push) - OCC_BITS'(pop && !take);
            if (take) begin
                left_reg      <= cmd.drains;
                busy_reg      <= (cmd.drains != '0);
                out_valid_reg <= 1'b1;
            end else if (pop) begin
                head_reg <= (head_reg == PTR_BITS'(BUFFER_DEPTH - 1)) ? '0
                            : head_reg + 1'b1;
                left_reg <= left_reg - 1'b1;
                busy_reg <= (left_reg != OCC_BITS'(1));
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule

>>> src/store_buffer_with_forwarding_core.sv
// Top level of the store buffer with forwarding.
// Depends on sbf_pkg, sbf_front and sbf_back.
//
// One word at a time, and a new word is taken only once the drain of the previous
// one is done. A store or flush word goes from the front to the back without a scan;
// a load word first scans the pending entries, one pending entry merged per cycle
// through the single entry read port, and its result follows the scan. Each retired
// entry then gives one write word per cycle while out_ready holds. No clearing pass
// after reset.
module store_buffer_with_forwarding_core import sbf_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              operation,
    input  logic [ADDRESS_BITS-1:0] address,
    input  logic [1:0]              size_code,
    input  logic [63:0]             store_data,
    input  logic [63:0]             memory_data,
    input  logic [4:0]              drain_count,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              result_kind,
    output logic [63:0]             load_data,
    output logic [ADDRESS_BITS-1:0] write_address,
    output logic [63:0]             write_data,
    output logic [1:0]              write_size_code,
    output logic                    last
);
    logic [OCC_BITS-1:0]     occupancy;
    logic [PTR_BITS-1:0]     head, rd_index;
    logic [ADDRESS_BITS-1:0] rd_address, push_address;
    logic [63:0]             rd_data, push_data;
    logic [1:0]              rd_size, push_size;
    logic                    push, cmd_valid, cmd_ready, drain_busy;
    cmd_t                    cmd;

    sbf_front u_front (
        .clk, .rst_n, .valid(in_valid), .ready(in_ready),
        .operation, .address, .size_code, .store_data, .memory_data, .drain_count,
        .occupancy, .head, .drain_busy, .rd_address, .rd_data, .rd_size, .rd_index,
        .push, .push_address, .push_data, .push_size,
        .cmd_valid, .cmd, .cmd_ready
    );

    sbf_back u_back (
        .clk, .rst_n, .push, .push_address, .push_data, .push_size,
        .rd_index, .rd_address, .rd_data, .rd_size, .occupancy, .head, .drain_busy,
        .cmd_valid, .cmd, .cmd_ready,
        .out_valid, .out_ready, .result_kind, .load_data, .write_address,
        .write_data, .write_size_code, .last
    );
endmodule

>>> src/sbf_checker.sv
// Port-level checks for the store buffer with forwarding.
// Depends on sbf_pkg; bound to store_buffer_with_forwarding_core.
module sbf_checker import sbf_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic [63:0] load_data,
    input logic [63:0] write_data,
    input logic        last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind))
        else $error("result dropped while stalled");
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != RK_LOAD |-> load_data == '0)
        else $error("load data on non-load word");
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != RK_WRITE |-> write_data == '0)
        else $error("write data on non-write word");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken mid-sequence");
endmodule

bind store_buffer_with_forwarding_core sbf_checker u_sbf_checker (
    .clk, .rst_n, .in_ready, .out_valid, .out_ready,
    .result_kind, .load_data, .write_data, .last
);

>>> verif/store_buffer_with_forwarding_core_tb.sv
// Self-checking testbench for store_buffer_with_forwarding_core.
// Directed table then random loads/stores/flushes, checked against a local predictor.
// Depends on sbf_pkg and the core RTL.
`timescale 1ns / 100ps

module store_buffer_with_forwarding_core_tb;
    import sbf_pkg::*;

    localparam int EXP_DEPTH  = 16384;
    localparam int ROWS_DEPTH = 32;

    typedef struct {
        logic [1:0]              op;
        logic [ADDRESS_BITS-1:0] addr;
        logic [1:0]              sz;
        logic [63:0]             sdata;
        logic [63:0]             mdata;
        logic [4:0]              dcnt;
        bit                      has_exp;
        logic [63:0]             exp_load;
    } stim_t;

    typedef struct {
        logic [1:0]              kind;
        logic [63:0]             ld;
        logic [ADDRESS_BITS-1:0] wa;
        logic [63:0]             wd;
        logic [1:0]              ws;
        logic                    lst;
    } word_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [1:0] operation, size_code;
    logic [ADDRESS_BITS-1:0] address;
    logic [63:0] store_data, memory_data;
    logic [4:0] drain_count;
    logic [1:0] result_kind, write_size_code;
    logic [63:0] load_data, write_data;
    logic [ADDRESS_BITS-1:0] write_address;
    logic last;

    store_buffer_with_forwarding_core u_dut (.*);

    // predictor state
    logic [ADDRESS_BITS-1:0] sb_addr [BUFFER_DEPTH];
    logic [63:0]             sb_data [BUFFER_DEPTH];
    logic [1:0]              sb_size [BUFFER_DEPTH];
    int sb_head, sb_tail, sb_occ;

    word_t exp_words [EXP_DEPTH];
    int exp_wr, exp_rd;
    int errors, n_words, n_loads, n_fwd, n_writes, cycles;
    bit hold_off, start_hold;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("timeout at %0t", $time);
                $display("store_buffer_with_forwarding_core_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [63:0] size_mask(logic [1:0] c);
        return (c == 2'd3) ? '1 : ((64'd1 << (8 << c)) - 64'd1);
    endfunction

    function automatic void push_word(logic [1:0] k, logic [63:0] ld,
                                      logic [ADDRESS_BITS-1:0] wa,
                                      logic [63:0] wd, logic [1:0] ws);
        word_t w;
        w.kind = k; w.ld = ld; w.wa = wa; w.wd = wd; w.ws = ws; w.lst = 1'b0;
        exp_words[exp_wr] = w;
        exp_wr++;
    endfunction

    function automatic void retire(int cnt);
        while (cnt > 0 && sb_occ > 0)
        begin
            push_word(RK_WRITE, '0, sb_addr[sb_head], sb_data[sb_head], sb_size[sb_head]);
            sb_head = (sb_head + 1) % BUFFER_DEPTH;
            sb_occ--;
            cnt--;
            n_writes++;
        end
    endfunction

    function automatic logic [63:0] forward_load(logic [ADDRESS_BITS-1:0] a,
                                                 logic [1:0] c, logic [63:0] m);
        logic [63:0] v;
        logic [7:0] b;
        logic [ADDRESS_BITS-1:0] off;
        int idx;
        v = '0;
        for (int i = 0; i < (1 << c); i++)
        begin
            b = m[8*i +: 8];
            idx = sb_head;
            for (int k = 0; k < sb_occ; k++)
            begin
                off = a + ADDRESS_BITS'(i) - sb_addr[idx];
                if (off < (1 << sb_size[idx]))
                begin
                    b = sb_data[idx][8*off[2:0] +: 8];
                    n_fwd++;
                end
                idx = (idx + 1) % BUFFER_DEPTH;
            end
            v[8*i +: 8] = b;
        end
        return v;
    endfunction

    // returns the expected first-word load data (for table checks)
    function automatic logic [63:0] predict_item(stim_t s);
        logic [63:0] lv;
        lv = '0;
        if (s.op == OP_NONE)
            return lv;
        if (s.op == OP_FLUSH)
        begin
            push_word(RK_FLUSH, '0, '0, '0, '0);
            retire(BUFFER_DEPTH);
        end
        else
        begin
            if (s.op == OP_LOAD)
            begin
                lv = forward_load(s.addr, s.sz, s.mdata);
                push_word(RK_LOAD, lv, '0, '0, '0);
                n_loads++;
            end
            else
            begin
                sb_addr[sb_tail] = s.addr;
                sb_data[sb_tail] = s.sdata & size_mask(s.sz);
                sb_size[sb_tail] = s.sz;
                sb_tail = (sb_tail + 1) % BUFFER_DEPTH;
                sb_occ++;
                push_word(RK_STORE, '0, '0, '0, '0);
            end
            retire(sb_occ >= BUFFER_DEPTH ? BUFFER_DEPTH : int'(s.dcnt));
        end
        exp_words[exp_wr-1].lst = 1'b1;
        return lv;
    endfunction

    task automatic send(stim_t s, bit may_idle);
        logic [63:0] lv;
        while (may_idle && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= s.op; address <= s.addr; size_code <= s.sz;
        store_data <= s.sdata; memory_data <= s.mdata; drain_count <= s.dcnt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lv = predict_item(s);
        if (s.has_exp && lv !== s.exp_load)
        begin
            $display("%0t table load: expected %h actual-predicted %h", $time, s.exp_load, lv);
            errors++;
        end
    endtask

    function automatic stim_t mk(logic [1:0] op, logic [ADDRESS_BITS-1:0] a, logic [1:0] sz,
                                 logic [63:0] sd, logic [63:0] md, logic [4:0] dc,
                                 bit he = 0, logic [63:0] el = '0);
        stim_t s;
        s.op = op; s.addr = a; s.sz = sz; s.sdata = sd; s.mdata = md; s.dcnt = dc;
        s.has_exp = he; s.exp_load = el;
        return s;
    endfunction

    function automatic stim_t rand_item();
        stim_t s;
        int r;
        r = $urandom_range(99);
        s.op = (r < 45) ? OP_STORE : (r < 90) ? OP_LOAD : (r < 97) ? OP_FLUSH : OP_NONE;
        // mostly a small address window so forwarding and overlaps are common
        if ($urandom_range(3) != 0)
            s.addr = {{ADDRESS_BITS-6{1'b0}}, 6'($urandom_range(63))} + 48'hFFFF_FFFF_FFE0;
        else
            s.addr = ADDRESS_BITS'({$urandom(), $urandom()});
        s.sz = 2'($urandom_range(3));
        s.sdata = {$urandom(), $urandom()};
        s.mdata = {$urandom(), $urandom()};
        s.dcnt = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(2));
        s.has_exp = 0;
        s.exp_load = '0;
        return s;
    endfunction

    // receiver
    initial
    begin
        word_t w;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
                out_ready <= 1'b0;
            else if (cycles > 2000 && cycles < 3500)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 37);
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                n_words++;
                if (exp_rd == exp_wr)
                begin
                    $display("%0t unexpected word kind=%0d", $time, result_kind);
                    errors++;
                end
                else
                begin
                    w = exp_words[exp_rd];
                    exp_rd++;
                    if (result_kind !== w.kind || load_data !== w.ld
                        || write_address !== w.wa || write_data !== w.wd
                        || write_size_code !== w.ws || last !== w.lst)
                    begin
                        $display("%0t mismatch: expected k=%0d ld=%h wa=%h wd=%h ws=%0d l=%b",
                                 $time, w.kind, w.ld, w.wa, w.wd, w.ws, w.lst);
                        $display("%0t           actual   k=%0d ld=%h wa=%h wd=%h ws=%0d l=%b",
                                 $time, result_kind, load_data, write_address,
                                 write_data, write_size_code, last);
                        errors++;
                    end
                end
            end
        end
    end

    // long receiver hold-off, counted here
    initial
    begin
        hold_off = 1'b0;
        wait (start_hold);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    stim_t table_rows [ROWS_DEPTH];
    int n_rows;

    initial
    begin
        errors = 0; n_words = 0; n_loads = 0; n_fwd = 0; n_writes = 0;
        sb_head = 0; sb_tail = 0; sb_occ = 0;
        exp_wr = 0; exp_rd = 0; n_rows = 0; start_hold = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_NONE; address = '0; size_code = '0;
        store_data = '0; memory_data = '0; drain_count = '0;
        // load on empty buffer returns memory bytes, masked to size
        table_rows[n_rows++] = mk(OP_LOAD, '0, 2'd0, '0, 64'hFFFF_FFFF_FFFF_FFA5, 5'd0,
                                  1, 64'hA5);
        table_rows[n_rows++] = mk(OP_LOAD, '1, 2'd3, '1, '1, 5'd31, 1, '1);
        table_rows[n_rows++] = mk(OP_FLUSH, '0, 2'd0, '0, '0, 5'd0);
        table_rows[n_rows++] = mk(OP_NONE, '1, 2'd3, '1, '1, 5'd31);
        table_rows[n_rows++] = mk(OP_STORE, 48'h100, 2'd3, 64'h0807_0605_0403_0201, '0, 5'd0);
        table_rows[n_rows++] = mk(OP_STORE, 48'h102, 2'd1, 64'hFFFF_FFFF_FFFF_BBAA, '0, 5'd0);
        table_rows[n_rows++] = mk(OP_LOAD, 48'h100, 2'd3, '0, '1, 5'd0, 1,
                                  64'h0807_0605_BBAA_0201);
        table_rows[n_rows++] = mk(OP_LOAD, 48'h104, 2'd2, '0, '0, 5'd1, 1, 64'h0807_0605);
        table_rows[n_rows++] = mk(OP_STORE, 48'hFFFF_FFFF_FFFE, 2'd2,
                                  64'h1122_3344_5566_7788, '0, 5'd0);
        table_rows[n_rows++] = mk(OP_LOAD, 48'h0, 2'd1, '0, '0, 5'd31);
        table_rows[n_rows++] = mk(OP_FLUSH, '0, 2'd0, '0, '0, 5'd0);
        for (int i = 0; i < 16; i++)
            table_rows[n_rows++] = mk(OP_STORE, 48'(i * 8), 2'(i), {$urandom(), $urandom()},
                                      '0, 5'd0);
        table_rows[n_rows++] = mk(OP_LOAD, 48'h8, 2'd3, '0, '0, 5'd16);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < n_rows; i++)
            send(table_rows[i], 1);
        for (int i = 0; i < 360; i++)
        begin
            if (i == 150)
                start_hold = 1'b1;
            send(rand_item(), !(i >= 60 && i < 140));
            if (i == 200)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (exp_rd != exp_wr)
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        while (exp_rd != exp_wr)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d words: %0d loads (%0d forwarded bytes), %0d memory writes",
                 n_words, n_loads, n_fwd, n_writes);
        if (errors == 0 && exp_rd == exp_wr)
            $display("store_buffer_with_forwarding_core_tb OK");
        else
            $display("store_buffer_with_forwarding_core_tb NOT OK");
        $finish;
    end
endmodule
